[src/ump_pkg.sv]
// ----------------------------------------------------------------------------
// ump_pkg
// Shared types and constants of the UART message frame parser.
// ----------------------------------------------------------------------------
`default_nettype none

package ump_pkg;

   // header and kind characters
   localparam logic [7:0] CHAR_M      = 8'h4D;
   localparam logic [7:0] CHAR_A      = 8'h41;
   localparam logic [7:0] CHAR_R      = 8'h52;
   localparam logic [7:0] CHAR_Y      = 8'h59;
   localparam logic [7:0] CHAR_D      = 8'h44;
   localparam logic [7:0] CHAR_W      = 8'h57;
   localparam logic [7:0] CHAR_P      = 8'h50;
   localparam logic [7:0] CHAR_C      = 8'h43;
   localparam logic [7:0] CHAR_B      = 8'h42;
   localparam logic [7:0] CHAR_T      = 8'h54;

   // link-info payload codes
   localparam logic [7:0] LINK_ATTEMPT_CODE = 8'h00;
   localparam logic [7:0] LINK_UP_CODE      = 8'h01;
   localparam logic [7:0] LINK_ACK_CODE     = 8'h52;

   localparam logic [7:0] LINK_FAIL_RESET = 8'd100;

   // message kinds
   localparam logic [3:0] KIND_PANEL   = 4'd0;
   localparam logic [3:0] KIND_SETTEMP = 4'd1;
   localparam logic [3:0] KIND_CMD     = 4'd2;
   localparam logic [3:0] KIND_CLOCK   = 4'd3;
   localparam logic [3:0] KIND_TIMING  = 4'd4;
   localparam logic [3:0] KIND_REF     = 4'd5;
   localparam logic [3:0] KIND_COPY    = 4'd6;
   localparam logic [3:0] KIND_LINKED  = 4'd7;
   localparam logic [3:0] KIND_ATTEMPT = 4'd8;
   localparam logic [3:0] KIND_ACK     = 4'd9;

   // label held while collecting payload; link info shares code 7
   localparam logic [3:0] LABEL_LINKINFO = 4'd7;

   // link status codes
   localparam logic [1:0] LINK_UNKNOWN = 2'd0;
   localparam logic [1:0] LINK_UP      = 2'd1;
   localparam logic [1:0] LINK_FAILED  = 2'd2;

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_HEADER = 6'b000010,
      ST_TYPE   = 6'b000100,
      ST_PAY1   = 6'b001000,
      ST_PAY2   = 6'b010000,
      ST_PAY3   = 6'b100000
   } parse_state_type;

   typedef struct packed {
      logic [3:0]  msg_kind;
      logic [7:0]  byte_first;
      logic [7:0]  byte_second;
      logic [7:0]  byte_third;
      logic [13:0] seconds_times_sixty;
      logic        decode_ready;
      logic [1:0]  link_status;
   } result_type;

endpackage

`default_nettype wire

[src/ump_if.sv]
// ----------------------------------------------------------------------------
// ump_if
// Valid/ready channels of the UART message frame parser.
// ----------------------------------------------------------------------------
`default_nettype none

interface ump_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface ump_rsp_if;
   logic        valid;
   logic        ready;
   logic [3:0]  msg_kind;
   logic [7:0]  byte_first;
   logic [7:0]  byte_second;
   logic [7:0]  byte_third;
   logic [13:0] seconds_times_sixty;
   logic        decode_ready;
   logic [1:0]  link_status;

   modport source (output valid, output msg_kind, output byte_first, output byte_second,
                   output byte_third, output seconds_times_sixty, output decode_ready,
                   output link_status, input ready);
   modport sink   (input valid, input msg_kind, input byte_first, input byte_second,
                   input byte_third, input seconds_times_sixty, input decode_ready,
                   input link_status, output ready);
endinterface

`default_nettype wire

[src/uart_message_frame_parser.sv]
// ----------------------------------------------------------------------------
// uart_message_frame_parser
// Parses framed UART messages byte by byte and reports completed messages.
// ----------------------------------------------------------------------------
//  channel  | direction | carries
//  ---------+-----------+-------------------------------------------------
//  req_bus  | in        | rx_byte, one received byte per transfer
//  rsp_bus  | out       | one completed message with link status
//  csr_*    | in        | link_fail_threshold write, no read-back
//
//  one byte per cycle while rsp_bus is not stalled; a byte waits in the input
//  register, and a result is registered as the parser takes its last byte.
//  the input register advances into the parser whenever the result register
//  is empty or being drained, so a stalled rsp_bus holds off req_bus.
//  synchronous reset returns the parser to idle, clears link tracking and
//  loads the threshold with 100.
// ----------------------------------------------------------------------------
`default_nettype none

module uart_message_frame_parser (
   input  wire logic       clock,
   input  wire logic       reset,
   ump_req_if.sink         req_bus,
   ump_rsp_if.source       rsp_bus,
   input  wire logic       csr_write_enable,
   input  wire logic [7:0] csr_write_data
);
   import ump_pkg::*;

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff, in_byte_in;
   logic [7:0] threshold_ff;
   logic       advance;
   logic       out_free;
   logic       emit;
   result_type result;
   result_type rsp_data;

   assign advance       = in_valid_ff && out_free;
   assign req_bus.ready = !in_valid_ff || out_free;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      if (req_bus.valid && req_bus.ready) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_bus.rx_byte;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         threshold_ff <= LINK_FAIL_RESET;
      end else begin
         in_valid_ff <= in_valid_in;
         if (csr_write_enable) threshold_ff <= csr_write_data;
      end
      in_byte_ff <= in_byte_in;
   end

   ump_parser u_parser (
      .clock          (clock),
      .reset          (reset),
      .step           (advance),
      .rx_byte        (in_byte_ff),
      .fail_threshold (threshold_ff),
      .emit           (emit),
      .result         (result)
   );

   ump_rsp_reg u_rsp_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (emit),
      .load_data (result),
      .out_ready (rsp_bus.ready),
      .out_valid (rsp_bus.valid),
      .out_data  (rsp_data),
      .free      (out_free)
   );

   assign rsp_bus.msg_kind            = rsp_data.msg_kind;
   assign rsp_bus.byte_first          = rsp_data.byte_first;
   assign rsp_bus.byte_second         = rsp_data.byte_second;
   assign rsp_bus.byte_third          = rsp_data.byte_third;
   assign rsp_bus.seconds_times_sixty = rsp_data.seconds_times_sixty;
   assign rsp_bus.decode_ready        = rsp_data.decode_ready;
   assign rsp_bus.link_status         = rsp_data.link_status;

endmodule

`default_nettype wire

[src/ump_parser.sv]
// ----------------------------------------------------------------------------
// ump_parser
// Frame state machine and link tracking; decodes one byte per step.
// ----------------------------------------------------------------------------
`default_nettype none

module ump_parser (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               step,
   input  wire logic [7:0]         rx_byte,
   input  wire logic [7:0]         fail_threshold,
   output      logic               emit,
   output      ump_pkg::result_type result
);
   import ump_pkg::*;

   parse_state_type state_ff, state_in;
   logic [3:0]      label_ff, label_in;
   logic [7:0]      first_ff, first_in;
   logic [7:0]      second_ff, second_in;
   logic [7:0]      attempts_ff, attempts_in;
   logic [1:0]      link_ff, link_in;
   logic [7:0]      attempts_inc;
   logic [13:0]     times_sixty;

   assign attempts_inc = attempts_ff + 8'd1;
   // x*60 = x*64 - x*4
   assign times_sixty  = {rx_byte, 6'b0} - {4'b0, rx_byte, 2'b0};

   always_comb begin
      state_in    = state_ff;
      label_in    = label_ff;
      first_in    = first_ff;
      second_in   = second_ff;
      attempts_in = attempts_ff;
      link_in     = link_ff;
      emit        = 1'b0;
      result      = '0;
      if (step) begin
         unique case (state_ff)
            ST_IDLE: begin
               if (rx_byte == CHAR_M) state_in = ST_HEADER;
            end
            ST_HEADER: begin
               priority if (rx_byte == CHAR_A) begin
                  state_in = ST_TYPE;
               end else if (rx_byte == CHAR_R) begin
                  label_in = KIND_REF;
                  state_in = ST_PAY1;
               end else if (rx_byte == CHAR_Y) begin
                  label_in = KIND_COPY;
                  state_in = ST_PAY1;
               end else begin
                  state_in = ST_IDLE;
               end
            end
            ST_TYPE: begin
               state_in = ST_PAY1;
               unique case (rx_byte)
                  CHAR_D:  label_in = KIND_PANEL;
                  CHAR_W:  label_in = LABEL_LINKINFO;
                  CHAR_P:  label_in = KIND_SETTEMP;
                  CHAR_C:  label_in = KIND_CMD;
                  CHAR_B:  label_in = KIND_CLOCK;
                  CHAR_T:  label_in = KIND_TIMING;
                  default: state_in = ST_IDLE;
               endcase
            end
            ST_PAY1: begin
               result.byte_first = rx_byte;
               unique case (label_ff)
                  KIND_PANEL, KIND_CLOCK, KIND_REF: begin
                     first_in = rx_byte;
                     state_in = ST_PAY2;
                  end
                  KIND_SETTEMP, KIND_TIMING, KIND_COPY: begin
                     emit                = 1'b1;
                     result.msg_kind     = label_ff;
                     result.decode_ready = (label_ff != KIND_COPY);
                  end
                  KIND_CMD: begin
                     attempts_in         = '0;
                     emit                = 1'b1;
                     result.msg_kind     = KIND_CMD;
                     result.decode_ready = 1'b1;
                  end
                  LABEL_LINKINFO: begin
                     // unknown link-info byte keeps waiting here
                     priority if (rx_byte == LINK_UP_CODE) begin
                        attempts_in         = '0;
                        link_in             = LINK_UP;
                        emit                = 1'b1;
                        result.msg_kind     = KIND_LINKED;
                        result.decode_ready = 1'b1;
                     end else if (rx_byte == LINK_ATTEMPT_CODE) begin
                        attempts_in = attempts_inc;
                        if (attempts_inc > fail_threshold) link_in = LINK_FAILED;
                        emit            = 1'b1;
                        result.msg_kind = KIND_ATTEMPT;
                     end else if (rx_byte == LINK_ACK_CODE) begin
                        emit            = 1'b1;
                        result.msg_kind = KIND_ACK;
                     end
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
            ST_PAY2: begin
               priority if (label_ff == KIND_PANEL) begin
                  emit                = 1'b1;
                  result.msg_kind     = KIND_PANEL;
                  result.byte_first   = first_ff;
                  result.byte_second  = rx_byte;
                  result.decode_ready = 1'b1;
               end else if (label_ff == KIND_CLOCK || label_ff == KIND_REF) begin
                  second_in = rx_byte;
                  state_in  = ST_PAY3;
               end else begin
                  state_in = ST_IDLE;
               end
            end
            ST_PAY3: begin
               if (label_ff == KIND_CLOCK || label_ff == KIND_REF) begin
                  emit                = 1'b1;
                  result.msg_kind     = label_ff;
                  result.byte_first   = first_ff;
                  result.byte_second  = second_ff;
                  result.byte_third   = rx_byte;
                  result.decode_ready = (label_ff == KIND_CLOCK);
                  if (label_ff == KIND_CLOCK) result.seconds_times_sixty = times_sixty;
               end else begin
                  state_in = ST_IDLE;
               end
            end
            default: state_in = ST_IDLE;
         endcase
         if (emit) state_in = ST_IDLE;
      end
      result.link_status = link_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         label_ff    <= '0;
         first_ff    <= '0;
         second_ff   <= '0;
         attempts_ff <= '0;
         link_ff     <= LINK_UNKNOWN;
      end else begin
         state_ff    <= state_in;
         label_ff    <= label_in;
         first_ff    <= first_in;
         second_ff   <= second_in;
         attempts_ff <= attempts_in;
         link_ff     <= link_in;
      end
   end

endmodule

`default_nettype wire

[src/ump_rsp_reg.sv]
// ----------------------------------------------------------------------------
// ump_rsp_reg
// Result register that holds a finished message until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module ump_rsp_reg (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                load,
   input  wire ump_pkg::result_type load_data,
   input  wire logic                out_ready,
   output      logic                out_valid,
   output      ump_pkg::result_type out_data,
   output      logic                free
);
   import ump_pkg::*;

   logic       valid_ff, valid_in;
   result_type data_ff, data_in;

   assign free = !valid_ff || out_ready;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (load) begin
         valid_in = 1'b1;
         data_in  = load_data;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

[src/ump_checker.sv]
// ----------------------------------------------------------------------------
// ump_checker
// Port-level checks of the UART message frame parser, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module ump_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [3:0]  msg_kind,
   input wire logic [7:0]  byte_third,
   input wire logic [13:0] seconds_times_sixty,
   input wire logic        decode_ready,
   input wire logic [1:0]  link_status
);
   import ump_pkg::*;

   // a stalled result keeps its contents
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(msg_kind) && $stable(byte_third))
      else $error("result changed while stalled");

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_seconds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> seconds_times_sixty ==
         ((msg_kind == KIND_CLOCK) ? (14'(byte_third) * 14'd60) : 14'd0))
      else $error("seconds field does not match third byte");

   a_decode_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && decode_ready |-> msg_kind == KIND_PANEL || msg_kind == KIND_SETTEMP ||
         msg_kind == KIND_CMD || msg_kind == KIND_CLOCK || msg_kind == KIND_TIMING ||
         msg_kind == KIND_LINKED)
      else $error("decode flag on a kind that is not decoded");

   a_link_after_linked: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && msg_kind == KIND_LINKED |-> link_status == LINK_UP)
      else $error("linked message without linked status");

endmodule

bind uart_message_frame_parser ump_checker u_ump_checker (
   .clock               (clock),
   .reset               (reset),
   .rsp_valid           (rsp_bus.valid),
   .rsp_ready           (rsp_bus.ready),
   .msg_kind            (rsp_bus.msg_kind),
   .byte_third          (rsp_bus.byte_third),
   .seconds_times_sixty (rsp_bus.seconds_times_sixty),
   .decode_ready        (rsp_bus.decode_ready),
   .link_status         (rsp_bus.link_status)
);

`default_nettype wire

[sim/tb_uart_message_frame_parser.sv]
// ----------------------------------------------------------------------------
// tb_uart_message_frame_parser
// Feeds framed byte streams into the parser and checks each completed message
// against a cycle-free model of the framing, link counter and link status.
// Random gaps on the byte channel and stalls on the result channel are mixed
// with quiet stretches; the threshold is rewritten between phases.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_uart_message_frame_parser;
   import ump_pkg::*;

   localparam int unsigned QUIET_LIMIT  = 1000;
   localparam int unsigned DRAIN_CYCLES = 6;

   logic       clock = 1'b0;
   logic       reset;
   logic       csr_write_enable;
   logic [7:0] csr_write_data;

   ump_req_if req_bus ();
   ump_rsp_if rsp_bus ();

   uart_message_frame_parser dut (
      .clock            (clock),
      .reset            (reset),
      .req_bus          (req_bus),
      .rsp_bus          (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // parser model state
   parse_state_type parse_phase;
   logic [3:0]      held_label;
   logic [7:0]      held_first;
   logic [7:0]      held_second;
   logic [7:0]      attempt_count;
   logic [1:0]      link_state;
   logic [7:0]      fail_threshold;

   result_type  pending_msgs[$];
   bit          idle_on;
   int unsigned fail_count;
   int unsigned bytes_sent;
   int unsigned msgs_checked;
   int unsigned csr_writes;
   int unsigned stall_left;
   int unsigned quiet_cycles;
   logic [9:0]  kinds_seen;

   // ---------------------------------------------------------------- model
   task automatic post_message(input logic [3:0] kind, input logic [7:0] b1,
                               input logic [7:0] b2, input logic [7:0] b3,
                               input logic dec);
      result_type r;
      r.msg_kind            = kind;
      r.byte_first          = b1;
      r.byte_second         = b2;
      r.byte_third          = b3;
      r.seconds_times_sixty = (kind == KIND_CLOCK) ? {6'd0, b3} * 14'd60 : 14'd0;
      r.decode_ready        = dec;
      r.link_status         = link_state;
      pending_msgs.push_back(r);
      kinds_seen[kind] = 1'b1;
      parse_phase = ST_IDLE;
   endtask

   task automatic advance_parser(input logic [7:0] b);
      case (parse_phase)
         ST_IDLE: begin
            if (b == CHAR_M) parse_phase = ST_HEADER;
         end
         ST_HEADER: begin
            if (b == CHAR_A) begin
               parse_phase = ST_TYPE;
            end else if (b == CHAR_R) begin
               held_label = KIND_REF;
               parse_phase = ST_PAY1;
            end else if (b == CHAR_Y) begin
               held_label = KIND_COPY;
               parse_phase = ST_PAY1;
            end else begin
               parse_phase = ST_IDLE;
            end
         end
         ST_TYPE: begin
            parse_phase = ST_PAY1;
            case (b)
               CHAR_D:  held_label = KIND_PANEL;
               CHAR_W:  held_label = LABEL_LINKINFO;
               CHAR_P:  held_label = KIND_SETTEMP;
               CHAR_C:  held_label = KIND_CMD;
               CHAR_B:  held_label = KIND_CLOCK;
               CHAR_T:  held_label = KIND_TIMING;
               default: parse_phase = ST_IDLE;
            endcase
         end
         ST_PAY1: begin
            case (held_label)
               KIND_PANEL, KIND_CLOCK, KIND_REF: begin
                  held_first = b;
                  parse_phase = ST_PAY2;
               end
               KIND_SETTEMP: post_message(KIND_SETTEMP, b, 8'd0, 8'd0, 1'b1);
               KIND_CMD: begin
                  attempt_count = 8'd0;
                  post_message(KIND_CMD, b, 8'd0, 8'd0, 1'b1);
               end
               KIND_TIMING: post_message(KIND_TIMING, b, 8'd0, 8'd0, 1'b1);
               KIND_COPY:   post_message(KIND_COPY, b, 8'd0, 8'd0, 1'b0);
               LABEL_LINKINFO: begin
                  if (b == LINK_UP_CODE) begin
                     attempt_count = 8'd0;
                     link_state = LINK_UP;
                     post_message(KIND_LINKED, b, 8'd0, 8'd0, 1'b1);
                  end else if (b == LINK_ATTEMPT_CODE) begin
                     attempt_count = attempt_count + 8'd1;
                     if (attempt_count > fail_threshold) link_state = LINK_FAILED;
                     post_message(KIND_ATTEMPT, b, 8'd0, 8'd0, 1'b0);
                  end else if (b == LINK_ACK_CODE) begin
                     post_message(KIND_ACK, b, 8'd0, 8'd0, 1'b0);
                  end
                  // any other byte keeps waiting for a link code
               end
               default: parse_phase = ST_IDLE;
            endcase
         end
         ST_PAY2: begin
            if (held_label == KIND_PANEL) begin
               post_message(KIND_PANEL, held_first, b, 8'd0, 1'b1);
            end else if (held_label == KIND_CLOCK || held_label == KIND_REF) begin
               held_second = b;
               parse_phase = ST_PAY3;
            end else begin
               parse_phase = ST_IDLE;
            end
         end
         ST_PAY3: begin
            if (held_label == KIND_CLOCK)
               post_message(KIND_CLOCK, held_first, held_second, b, 1'b1);
            else if (held_label == KIND_REF)
               post_message(KIND_REF, held_first, held_second, b, 1'b0);
            else
               parse_phase = ST_IDLE;
         end
         default: parse_phase = ST_IDLE;
      endcase
   endtask

   // ---------------------------------------------------------------- driving
   task automatic send_byte(input logic [7:0] b);
      int unsigned gap;
      if (idle_on && $urandom_range(0, 7) == 0) begin
         gap = $urandom_range(1, 19);
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.rx_byte <= b;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      bytes_sent++;
      advance_parser(b);
   endtask

   // M, optionally A, the selector, then n payload bytes
   task automatic send_frame(input bit via_a, input logic [7:0] sel, input int unsigned n,
                             input logic [7:0] p1, input logic [7:0] p2,
                             input logic [7:0] p3);
      send_byte(CHAR_M);
      if (via_a) send_byte(CHAR_A);
      send_byte(sel);
      if (n > 0) send_byte(p1);
      if (n > 1) send_byte(p2);
      if (n > 2) send_byte(p3);
   endtask

   task automatic settle();
      req_bus.valid <= 1'b0;
      while (pending_msgs.size() != 0) @(posedge clock);
      // a frame that ended without a result may still be in the pipe
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_threshold(input logic [7:0] value);
      settle();
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      fail_threshold = value;
      csr_writes++;
   endtask

   function automatic logic [7:0] odd_link_byte();
      logic [7:0] v;
      do v = 8'($urandom);
      while (v == LINK_ATTEMPT_CODE || v == LINK_UP_CODE || v == LINK_ACK_CODE);
      return v;
   endfunction

   task automatic send_random_message();
      int unsigned pick;
      int unsigned extra;
      logic [7:0]  a;
      logic [7:0]  b;
      logic [7:0]  c;
      pick = $urandom_range(0, 15);
      a = 8'($urandom);
      b = 8'($urandom);
      c = 8'($urandom);
      case (pick)
         0, 1: send_frame(1'b1, CHAR_D, 2, a, b, c);
         2:    send_frame(1'b1, CHAR_P, 1, a, b, c);
         3:    send_frame(1'b1, CHAR_C, 1, a, b, c);
         4, 5: send_frame(1'b1, CHAR_B, 3, a, b, c);
         6:    send_frame(1'b1, CHAR_T, 1, a, b, c);
         7:    send_frame(1'b0, CHAR_R, 3, a, b, c);
         8:    send_frame(1'b0, CHAR_Y, 1, a, b, c);
         9, 10, 11: begin
            send_frame(1'b1, CHAR_W, 0, a, b, c);
            extra = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
            repeat (extra) send_byte(odd_link_byte());
            case ($urandom_range(0, 5))
               4:       send_byte(LINK_UP_CODE);
               5:       send_byte(LINK_ACK_CODE);
               default: send_byte(LINK_ATTEMPT_CODE);
            endcase
         end
         12: begin
            // bad type letter after A
            case ($urandom_range(0, 2))
               0:       send_frame(1'b1, CHAR_R, 0, a, b, c);
               1:       send_frame(1'b1, 8'h00, 0, a, b, c);
               default: send_frame(1'b1, a, 0, a, b, c);
            endcase
         end
         13: send_frame(1'b0, a, 0, a, b, c);
         14: send_frame(1'b1, CHAR_D, 1, a, b, c);   // cut short
         default: begin
            repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
         end
      endcase
   endtask

   // ---------------------------------------------------------------- tests
   task automatic test_directed_kinds();
      send_frame(1'b1, CHAR_B, 3, 8'hFF, 8'h00, 8'hFF);
      send_frame(1'b1, CHAR_D, 2, 8'h00, 8'hFF, 8'h00);
      send_frame(1'b0, CHAR_R, 3, 8'h01, 8'h80, 8'h7F);
      send_frame(1'b0, CHAR_Y, 1, 8'hAA, 8'h00, 8'h00);
      send_frame(1'b1, CHAR_P, 1, 8'h55, 8'h00, 8'h00);
      send_frame(1'b1, CHAR_C, 1, 8'h00, 8'h00, 8'h00);
      send_frame(1'b1, CHAR_T, 1, 8'hFF, 8'h00, 8'h00);
      send_frame(1'b1, CHAR_W, 1, LINK_ATTEMPT_CODE, 8'h00, 8'h00);
      send_frame(1'b1, CHAR_W, 1, LINK_UP_CODE, 8'h00, 8'h00);
      send_frame(1'b1, CHAR_W, 1, LINK_ACK_CODE, 8'h00, 8'h00);
   endtask

   task automatic test_malformed_frames();
      send_byte(8'h00);
      send_byte(8'hFF);
      send_frame(1'b0, 8'h51, 0, 8'h00, 8'h00, 8'h00);     // bad kind byte
      send_frame(1'b1, CHAR_R, 0, 8'h00, 8'h00, 8'h00);    // R as type letter
      send_frame(1'b1, 8'h00, 0, 8'h00, 8'h00, 8'h00);     // NUL as type letter
      send_frame(1'b1, 8'h5A, 0, 8'h00, 8'h00, 8'h00);     // unknown type letter
      // unknown link bytes, an M among them, are skipped while waiting
      send_frame(1'b1, CHAR_W, 3, 8'h33, CHAR_M, LINK_ATTEMPT_CODE);
   endtask

   task automatic test_link_tracking();
      write_threshold(8'd1);
      send_frame(1'b1, CHAR_W, 1, LINK_ATTEMPT_CODE, 8'h00, 8'h00);
      send_frame(1'b1, CHAR_C, 1, 8'h12, 8'h00, 8'h00);    // clears attempts only
      send_frame(1'b1, CHAR_W, 1, LINK_ATTEMPT_CODE, 8'h00, 8'h00);
      send_frame(1'b1, CHAR_W, 1, LINK_ATTEMPT_CODE, 8'h00, 8'h00);
      send_frame(1'b1, CHAR_C, 1, 8'h34, 8'h00, 8'h00);    // status stays failed
      send_frame(1'b1, CHAR_W, 1, LINK_UP_CODE, 8'h00, 8'h00);
      write_threshold(8'd0);
      send_frame(1'b1, CHAR_W, 1, LINK_ATTEMPT_CODE, 8'h00, 8'h00);
   endtask

   task automatic test_counter_wrap();
      write_threshold(8'd255);
      send_frame(1'b1, CHAR_W, 1, LINK_UP_CODE, 8'h00, 8'h00);
      repeat (256) send_frame(1'b1, CHAR_W, 1, LINK_ATTEMPT_CODE, 8'h00, 8'h00);
      // a saturating counter would fail on the first attempt below
      write_threshold(8'd3);
      repeat (4) send_frame(1'b1, CHAR_W, 1, LINK_ATTEMPT_CODE, 8'h00, 8'h00);
   endtask

   task automatic test_random_traffic();
      int unsigned phase_end;
      logic [7:0]  limits[5];
      limits[0] = 8'd0;
      limits[1] = 8'd255;
      limits[2] = 8'($urandom_range(2, 12));
      limits[3] = 8'($urandom);
      limits[4] = 8'd1;
      for (int phase = 0; phase < 5; phase++) begin
         write_threshold(limits[phase]);
         idle_on = (phase != 2 && phase != 4);
         phase_end = bytes_sent + 140;
         while (bytes_sent < phase_end) send_random_message();
      end
   endtask

   // ---------------------------------------------------------------- result side
   task automatic check_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected %0d, actual %0d", name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_bus.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 15) == 0) begin
         stall_left <= $urandom_range(0, 18);
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin : check_results
      result_type want;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (pending_msgs.size() == 0) begin
            $error("result with none pending: kind %0d", rsp_bus.msg_kind);
            fail_count++;
         end else begin
            want = pending_msgs.pop_front();
            check_field("msg_kind", 16'(want.msg_kind), 16'(rsp_bus.msg_kind));
            check_field("byte_first", 16'(want.byte_first), 16'(rsp_bus.byte_first));
            check_field("byte_second", 16'(want.byte_second), 16'(rsp_bus.byte_second));
            check_field("byte_third", 16'(want.byte_third), 16'(rsp_bus.byte_third));
            check_field("seconds_times_sixty", 16'(want.seconds_times_sixty),
                        16'(rsp_bus.seconds_times_sixty));
            check_field("decode_ready", 16'(want.decode_ready),
                        16'(rsp_bus.decode_ready));
            check_field("link_status", 16'(want.link_status), 16'(rsp_bus.link_status));
            msgs_checked++;
         end
      end
   end

   // ends the run when neither channel has moved for too long
   always @(posedge clock) begin
      if ((req_bus.valid === 1'b1 && req_bus.ready === 1'b1) ||
          (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("timeout: no transfer for %0d cycles", QUIET_LIMIT);
         $display("Simulation FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      reset            = 1'b1;
      csr_write_enable = 1'b0;
      csr_write_data   = 8'd0;
      req_bus.valid    = 1'b0;
      req_bus.rx_byte  = 8'd0;
      bytes_sent       = 0;
      csr_writes       = 0;
      kinds_seen       = '0;
      idle_on          = 1'b1;
      parse_phase      = ST_IDLE;
      held_label       = 4'd0;
      held_first       = 8'd0;
      held_second      = 8'd0;
      attempt_count    = 8'd0;
      link_state       = LINK_UNKNOWN;
      fail_threshold   = LINK_FAIL_RESET;

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_kinds();
      test_malformed_frames();
      test_link_tracking();
      test_counter_wrap();
      test_random_traffic();

      settle();
      repeat (8) @(posedge clock);

      $display("covered %0d received bytes, %0d messages checked, %0d threshold writes",
               bytes_sent, msgs_checked, csr_writes);
      $display("message kinds seen (bit per kind): %b", kinds_seen);
      if (fail_count == 0 && pending_msgs.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         if (pending_msgs.size() != 0)
            $error("%0d expected messages never arrived", pending_msgs.size());
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire
